FILE: rtl/core/jsl_pkg.sv
package jsl_pkg;

  localparam int KEY_MAX      = 8;
  localparam int POS_BITS     = 16;
  localparam int DEPTH_BITS   = 8;
  localparam int RECENT_DEPTH = KEY_MAX + 2;
  localparam int OFFSET_W     = 16;
  localparam int KEY_W        = 64;
  localparam int KEY_LEN_W    = 4;

  localparam logic [POS_BITS-1:0]   POS_MAX   = {POS_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_BLANKS = 2'd1;
  localparam logic [1:0] PH_OBJECT = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [2:0] ST_FOUND  = 3'd0;
  localparam logic [2:0] ST_NOKEY  = 3'd1;
  localparam logic [2:0] ST_NOTOBJ = 3'd2;
  localparam logic [2:0] ST_UNBAL  = 3'd3;
  localparam logic [2:0] ST_OVER   = 3'd4;

  localparam logic [0:0] REG_KEY_CHARS  = 1'b0;
  localparam logic [0:0] REG_KEY_LENGTH = 1'b1;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [OFFSET_W-1:0] object_start;
    logic [OFFSET_W-1:0] object_end;
  } result_t;

endpackage

FILE: rtl/core/jsl_in_reg.sv
module jsl_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_stall,
  input  jsl_pkg::item_t item,
  input  logic          fire,
  output logic          held_valid,
  output jsl_pkg::item_t held_item
);
  import jsl_pkg::*;

  logic accept;

  assign byte_stall = held_valid && !fire;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (fire) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_item <= item;
    end
  end

endmodule

FILE: rtl/core/jsl_scan.sv
module jsl_scan (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      held_valid,
  input  jsl_pkg::item_t            held_item,
  input  logic [jsl_pkg::KEY_W-1:0] key_chars,
  input  logic [jsl_pkg::KEY_LEN_W-1:0] key_length,
  input  logic                      out_free,
  output logic                      fire,
  output logic                      res_valid,
  output jsl_pkg::result_t          result
);
  import jsl_pkg::*;

  logic [1:0]            phase, phase_next;
  logic [7:0]            recent [RECENT_DEPTH];
  logic [POS_BITS-1:0]   byte_position, byte_position_next;
  logic [POS_BITS-1:0]   brace_start, brace_start_next;
  logic [DEPTH_BITS-1:0] nesting_depth, nesting_depth_next;
  logic                  inside_string, inside_string_next;
  logic                  escape_pending, escape_pending_next;

  logic [KEY_LEN_W-1:0]  len;
  logic [KEY_MAX:0]      len_match;
  logic                  hit;
  logic [7:0]            c;
  logic                  last;
  logic [DEPTH_BITS-1:0] depth_dec;

  assign c    = held_item.text_byte;
  assign last = held_item.last_byte;
  assign len  = (key_length > KEY_LEN_W'(KEY_MAX)) ? KEY_LEN_W'(KEY_MAX) : key_length;

  // one candidate per key length, all at fixed taps
  always_comb begin
    for (int l = 0; l <= KEY_MAX; l++) begin
      len_match[l] = (recent[0] == CH_QUOTE) && (recent[l+1] == CH_QUOTE);
      for (int k = 0; k < KEY_MAX; k++) begin
        if (k < l) begin
          if (recent[l-k] != key_chars[8*k +: 8]) begin
            len_match[l] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int l = 0; l <= KEY_MAX; l++) begin
      if (len == KEY_LEN_W'(l)) begin
        hit = len_match[l];
      end
    end
    hit = hit && (c == CH_COLON);
  end

  assign depth_dec = (nesting_depth != '0) ? nesting_depth - 1'b1 : '0;

  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    brace_start_next    = brace_start;
    nesting_depth_next  = nesting_depth;
    inside_string_next  = inside_string;
    escape_pending_next = escape_pending;
    res_valid           = 1'b0;
    result.status       = ST_FOUND;
    result.object_start = '0;
    result.object_end   = '0;

    unique case (phase)
      PH_SEARCH: begin
        if (hit) begin
          phase_next = PH_BLANKS;
        end
      end
      PH_BLANKS: begin
        if (c == CH_LBRACE) begin
          brace_start_next    = byte_position;
          nesting_depth_next  = DEPTH_BITS'(1);
          inside_string_next  = 1'b0;
          escape_pending_next = 1'b0;
          phase_next          = PH_OBJECT;
        end else if (c != CH_SPACE && c != CH_TAB) begin
          res_valid     = 1'b1;
          result.status = ST_NOTOBJ;
          phase_next    = PH_DONE;
        end
      end
      PH_OBJECT: begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
        end else if (inside_string) begin
          if (c == CH_BSLASH) begin
            escape_pending_next = 1'b1;
          end else if (c == CH_QUOTE) begin
            inside_string_next = 1'b0;
          end
        end else if (c == CH_QUOTE) begin
          inside_string_next = 1'b1;
        end else if (c == CH_LBRACE) begin
          if (nesting_depth == DEPTH_MAX) begin
            res_valid     = 1'b1;
            result.status = ST_OVER;
            phase_next    = PH_DONE;
          end else begin
            nesting_depth_next = nesting_depth + 1'b1;
          end
        end else if (c == CH_RBRACE) begin
          nesting_depth_next = depth_dec;
          if (depth_dec == '0) begin
            res_valid           = 1'b1;
            result.status       = ST_FOUND;
            result.object_start = OFFSET_W'(brace_start);
            result.object_end   = OFFSET_W'(byte_position);
            phase_next          = PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase

    if (!res_valid && phase_next != PH_DONE) begin
      if (last) begin
        res_valid     = 1'b1;
        result.status = (phase_next == PH_SEARCH) ? ST_NOKEY :
                        (phase_next == PH_BLANKS) ? ST_NOTOBJ : ST_UNBAL;
        phase_next    = PH_DONE;
      end else if (byte_position == POS_MAX) begin
        res_valid     = 1'b1;
        result.status = ST_OVER;
        phase_next    = PH_DONE;
      end else begin
        byte_position_next = byte_position + 1'b1;
      end
    end
  end

  assign fire = held_valid && (!res_valid || out_free);

  always_ff @(posedge clk) begin
    if (rst || (fire && last)) begin
      phase          <= PH_SEARCH;
      byte_position  <= '0;
      brace_start    <= '0;
      nesting_depth  <= '0;
      inside_string  <= 1'b0;
      escape_pending <= 1'b0;
      for (int i = 0; i < RECENT_DEPTH; i++) begin
        recent[i] <= '0;
      end
    end else if (fire) begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      brace_start    <= brace_start_next;
      nesting_depth  <= nesting_depth_next;
      inside_string  <= inside_string_next;
      escape_pending <= escape_pending_next;
      if (phase == PH_SEARCH) begin
        recent[0] <= c;
        for (int i = 1; i < RECENT_DEPTH; i++) begin
          recent[i] <= recent[i-1];
        end
      end
    end
  end

endmodule

FILE: rtl/core/jsl_out_reg.sv
module jsl_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  jsl_pkg::result_t result,
  output logic             out_free,
  output logic             result_valid,
  input  logic             result_stall,
  output jsl_pkg::result_t held
);
  import jsl_pkg::*;

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

FILE: rtl/core/json_subobject_locator.sv
// channel  | handshake                 | payload
// ---------+---------------------------+--------------------------------------
// byte     | byte_valid / byte_stall   | text_byte, last_byte
// result   | result_valid/result_stall | status, object_start, object_end
// cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One byte per cycle unless the result channel stalls; an accepted byte waits in the
// input register, and any result it yields is loaded into the result register.
// Synchronous reset clears scan state and key registers; cfg_ready is always high.
// A byte without a result never waits; a byte with one waits only while the
// result register is full and stalled.
module json_subobject_locator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             byte_valid,
  output logic                             byte_stall,
  input  logic [7:0]                       text_byte,
  input  logic                             last_byte,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [2:0]                       status,
  output logic [jsl_pkg::OFFSET_W-1:0]     object_start,
  output logic [jsl_pkg::OFFSET_W-1:0]     object_end,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [0:0]                       cfg_index,
  input  logic [jsl_pkg::KEY_W-1:0]        cfg_data
);
  import jsl_pkg::*;

  logic [KEY_W-1:0]     key_chars;
  logic [KEY_LEN_W-1:0] key_length;
  item_t                item;
  item_t                held_item;
  logic                 held_valid;
  logic                 fire;
  logic                 res_valid;
  logic                 out_free;
  result_t              result;
  result_t              held_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_chars  <= '0;
      key_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_CHARS:  key_chars  <= cfg_data;
        REG_KEY_LENGTH: key_length <= cfg_data[KEY_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign item.text_byte = text_byte;
  assign item.last_byte = last_byte;

  jsl_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .item       (item),
    .fire       (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  jsl_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_item  (held_item),
    .key_chars  (key_chars),
    .key_length (key_length),
    .out_free   (out_free),
    .fire       (fire),
    .res_valid  (res_valid),
    .result     (result)
  );

  jsl_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (fire && res_valid),
    .result       (result),
    .out_free     (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .held         (held_result)
  );

  assign status       = held_result.status;
  assign object_start = held_result.object_start;
  assign object_end   = held_result.object_end;

endmodule

FILE: tb/sv/span_check.sv
module span_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  input  logic                          byte_stall,
  input  logic [7:0]                    text_byte,
  input  logic                          last_byte,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  logic [2:0]                    status,
  input  logic [jsl_pkg::OFFSET_W-1:0]  object_start,
  input  logic [jsl_pkg::OFFSET_W-1:0]  object_end,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [0:0]                    cfg_index,
  input  logic [jsl_pkg::KEY_W-1:0]     cfg_data,
  output int                            fails,
  output int                            pending,
  output int                            checked
);
  import jsl_pkg::*;

  logic [KEY_W-1:0]      key_word;
  logic [KEY_LEN_W-1:0]  key_len;
  logic [1:0]            scan_phase;
  logic [7:0]            window [RECENT_DEPTH];
  logic [POS_BITS-1:0]   offset;
  logic [POS_BITS-1:0]   open_at;
  logic [DEPTH_BITS-1:0] level;
  logic                  in_quote;
  logic                  skip_next;
  result_t               span_due [$];
  int                    misses = 0;
  int                    seen = 0;

  function automatic result_t make_span(input logic [2:0] st, input logic [POS_BITS-1:0] s,
                                        input logic [POS_BITS-1:0] e);
    result_t r;
    r.status       = st;
    r.object_start = OFFSET_W'(s);
    r.object_end   = OFFSET_W'(e);
    return r;
  endfunction

  function automatic bit key_seen(input logic [7:0] c);
    int n;
    int k;
    bit ok;
    n  = (key_len > KEY_MAX) ? KEY_MAX : int'(key_len);
    ok = (c == CH_COLON) && (window[0] == CH_QUOTE) && (window[n + 1] == CH_QUOTE);
    for (k = 0; k < n; k++) begin
      if (window[n - k] != key_word[8 * k +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  task automatic clear_scan();
    int i;
    scan_phase = PH_SEARCH;
    for (i = 0; i < RECENT_DEPTH; i++) window[i] = '0;
    offset    = '0;
    open_at   = '0;
    level     = '0;
    in_quote  = 1'b0;
    skip_next = 1'b0;
  endtask

  task automatic advance_scan(input logic [7:0] c, input logic fin);
    result_t r;
    bit decided;
    bit hit;
    int i;
    decided = 1'b0;
    r = make_span(ST_FOUND, '0, '0);
    case (scan_phase)
      PH_SEARCH: begin
        hit = key_seen(c);
        for (i = RECENT_DEPTH - 1; i > 0; i--) window[i] = window[i - 1];
        window[0] = c;
        if (hit) scan_phase = PH_BLANKS;
      end
      PH_BLANKS: begin
        if (c == CH_LBRACE) begin
          open_at    = offset;
          level      = DEPTH_BITS'(1);
          in_quote   = 1'b0;
          skip_next  = 1'b0;
          scan_phase = PH_OBJECT;
        end else if (c != CH_SPACE && c != CH_TAB) begin
          r = make_span(ST_NOTOBJ, '0, '0);
          decided = 1'b1;
        end
      end
      PH_OBJECT: begin
        if (skip_next) begin
          skip_next = 1'b0;
        end else if (in_quote) begin
          if (c == CH_BSLASH) skip_next = 1'b1;
          else if (c == CH_QUOTE) in_quote = 1'b0;
        end else if (c == CH_QUOTE) begin
          in_quote = 1'b1;
        end else if (c == CH_LBRACE) begin
          if (level == DEPTH_MAX) begin
            r = make_span(ST_OVER, '0, '0);
            decided = 1'b1;
          end else begin
            level++;
          end
        end else if (c == CH_RBRACE) begin
          if (level != 0) level--;
          if (level == 0) begin
            r = make_span(ST_FOUND, open_at, offset);
            decided = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (!decided && scan_phase != PH_DONE) begin
      if (fin) begin
        r = make_span(scan_phase == PH_SEARCH ? ST_NOKEY :
                      scan_phase == PH_BLANKS ? ST_NOTOBJ : ST_UNBAL, '0, '0);
        decided = 1'b1;
      end else if (offset == POS_MAX) begin
        r = make_span(ST_OVER, '0, '0);
        decided = 1'b1;
      end else begin
        offset++;
      end
    end
    if (decided) begin
      span_due.push_back(r);
      scan_phase = PH_DONE;
    end
    if (fin) clear_scan();
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      key_word = '0;
      key_len  = '0;
      clear_scan();
      span_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_KEY_CHARS) key_word = cfg_data;
        else key_len = cfg_data[KEY_LEN_W-1:0];
      end
      if (byte_valid && !byte_stall) advance_scan(text_byte, last_byte);
      if (result_valid && !result_stall) begin
        seen++;
        if (span_due.size() == 0) begin
          misses++;
          if (misses <= 10)
            $display("unexpected result: status %0d start %0d end %0d",
                     status, object_start, object_end);
        end else begin
          want = span_due.pop_front();
          if (status !== want.status || object_start !== want.object_start ||
              object_end !== want.object_end) begin
            misses++;
            if (misses <= 10)
              $display("result %0d: expected status %0d start %0d end %0d, got %0d %0d %0d",
                       seen, want.status, want.object_start, want.object_end,
                       status, object_start, object_end);
          end
        end
      end
    end
    pending <= span_due.size();
    fails   <= misses;
    checked <= seen;
  end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  import jsl_pkg::*;

  localparam int LIMIT = 1_000_000;

  logic                clk;
  logic                rst = 1'b1;
  logic                byte_valid = 1'b0;
  logic                byte_stall;
  logic [7:0]          text_byte = '0;
  logic                last_byte = 1'b0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [2:0]          status;
  logic [OFFSET_W-1:0] object_start;
  logic [OFFSET_W-1:0] object_end;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [0:0]          cfg_index = '0;
  logic [KEY_W-1:0]    cfg_data = '0;

  int fails;
  int pending;
  int checked;
  int cycles = 0;
  int texts = 0;
  int bytes_sent = 0;
  int settings = 0;
  bit quiet = 1'b0;

  logic [KEY_W-1:0]     cur_key = '0;
  logic [KEY_LEN_W-1:0] cur_len = '0;
  logic [7:0]           text_q [$];

  json_subobject_locator i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .text_byte    (text_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .object_start (object_start),
    .object_end   (object_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  span_check i_check (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .text_byte    (text_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .object_start (object_start),
    .object_end   (object_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fails        (fails),
    .pending      (pending),
    .checked      (checked)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk) result_stall <= !quiet && ($urandom_range(99) < 24);

  task automatic put_byte(input logic [7:0] b, input logic fin);
    while (!quiet && $urandom_range(99) < 24) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    text_byte  <= b;
    last_byte  <= fin;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++) put_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    texts++;
  endtask

  // drain the result channel, then hold off while the pipeline empties
  task automatic settle();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_key(input logic [KEY_W-1:0] chars, input logic [KEY_LEN_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_index <= REG_KEY_CHARS;
    cfg_data  <= chars;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_KEY_LENGTH;
    cfg_data  <= {32'($urandom), 28'($urandom), len};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_key = chars;
    cur_len = len;
    settings++;
  endtask

  task automatic add_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic add_noise(input int n);
    string junk;
    int i;
    junk = "\"{}:\\ ab\t,";
    for (i = 0; i < n; i++) begin
      if ($urandom_range(1)) text_q.push_back(8'($urandom_range(255)));
      else text_q.push_back(junk[$urandom_range(junk.len() - 1)]);
    end
  endtask

  task automatic add_blanks(input int n);
    int i;
    for (i = 0; i < n; i++) text_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic add_key_tag(input bit spoil);
    logic [7:0] tag [$];
    int eff;
    int k;
    int at;
    eff = (cur_len > KEY_MAX) ? KEY_MAX : int'(cur_len);
    tag.push_back(CH_QUOTE);
    for (k = 0; k < eff; k++) tag.push_back(cur_key[8 * k +: 8]);
    tag.push_back(CH_QUOTE);
    tag.push_back(CH_COLON);
    if (spoil) begin
      at = $urandom_range(tag.size() - 1);
      tag[at] = tag[at] ^ 8'($urandom_range(1, 255));
    end
    foreach (tag[k]) text_q.push_back(tag[k]);
  endtask

  task automatic add_object(input int budget, input bit cut);
    string filler;
    logic [7:0] b;
    int depth;
    int k;
    int n;
    filler = "a1,: \t[]";
    depth = 1;
    text_q.push_back(CH_LBRACE);
    for (k = 0; k < budget; k++) begin
      case ($urandom_range(5))
        0: if (depth < 4) begin
          text_q.push_back(CH_LBRACE);
          depth++;
        end
        1: if (depth > 1) begin
          text_q.push_back(CH_RBRACE);
          depth--;
        end
        2: begin
          text_q.push_back(CH_QUOTE);
          for (n = $urandom_range(4); n > 0; n--) begin
            b = $urandom_range(3) == 0 ? ($urandom_range(1) ? CH_LBRACE : CH_RBRACE) :
                8'($urandom_range(255));
            if (b == CH_QUOTE || b == CH_BSLASH || $urandom_range(5) == 0)
              text_q.push_back(CH_BSLASH);
            text_q.push_back(b);
          end
          text_q.push_back(CH_QUOTE);
        end
        default: begin
          if ($urandom_range(3) == 0) text_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
          else text_q.push_back(filler[$urandom_range(filler.len() - 1)]);
        end
      endcase
    end
    if (!cut) repeat (depth) text_q.push_back(CH_RBRACE);
  endtask

  task automatic make_random_text();
    logic [7:0] b;
    int kind;
    kind = $urandom_range(99);
    add_noise($urandom_range(6));
    if (kind < 8) begin
      add_noise($urandom_range(4, 20));
    end else if (kind < 16) begin
      add_key_tag(1'b1);
      add_blanks($urandom_range(2));
      add_object($urandom_range(0, 8), 1'b0);
    end else begin
      if ($urandom_range(3) == 0) add_key_tag(1'b1);
      add_key_tag(1'b0);
      add_blanks($urandom_range(3));
      if (kind < 26) begin
        do b = 8'($urandom_range(255));
        while (b == CH_LBRACE || b == CH_SPACE || b == CH_TAB);
        text_q.push_back(b);
      end else if (kind >= 34 && kind < 42) begin
        add_object($urandom_range(1, 10), 1'b1);
      end else if (kind >= 42) begin
        add_object($urandom_range(0, 12), 1'b0);
      end
      if (kind < 26 || kind >= 42) add_noise($urandom_range(4));
    end
    send_text();
  endtask

  initial begin
    int rand_texts;
    int base_bytes;
    int k;
    logic [KEY_W-1:0] chars;
    logic [KEY_LEN_W-1:0] len;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty key straight out of reset
    add_str("\"\":{}");
    send_text();

    settle();
    set_key(64'h6261, 4'd2);
    add_str("\"ab\":\t {\"\\\"}\"}");
    send_text();
    add_str("\"ab\":5x");
    send_text();
    add_str("\"ab\": ");
    send_text();
    add_str("\"ab\":{{}");
    send_text();
    add_str("xy");
    send_text();

    // nest one brace beyond the depth counter
    add_str("\"ab\":");
    repeat (256) text_q.push_back(CH_LBRACE);
    text_q.push_back(CH_RBRACE);
    send_text();

    // run the offset counter to its limit inside an object, then end on the limit
    quiet <= 1'b1;
    add_str("\"ab\":{");
    repeat (65531) text_q.push_back(8'h78);
    send_text();
    quiet <= 1'b0;
    repeat (65536) text_q.push_back(8'h78);
    send_text();

    settle();
    set_key('1, 4'd15);
    text_q.push_back(CH_QUOTE);
    repeat (8) text_q.push_back(8'hFF);
    add_str("\":{}");
    send_text();

    settle();
    set_key('0, 4'd3);
    text_q.push_back(CH_QUOTE);
    repeat (3) text_q.push_back(8'h00);
    add_str("\":[");
    send_text();

    rand_texts = 0;
    base_bytes = bytes_sent;
    while (bytes_sent - base_bytes < 900 || rand_texts < 60) begin
      if (rand_texts % 8 == 0) begin
        settle();
        len = (rand_texts == 0) ? 4'd8 : (rand_texts == 8) ? 4'd0 : 4'($urandom_range(15));
        for (k = 0; k < 8; k++)
          chars[8 * k +: 8] = $urandom_range(3) == 0 ? 8'($urandom_range(255)) :
                              8'($urandom_range(8'h61, 8'h7A));
        set_key(chars, len);
      end
      quiet <= (rand_texts >= 20 && rand_texts < 32);
      make_random_text();
      rand_texts++;
    end
    quiet <= 1'b0;
    settle();

    $display("covered %0d texts and %0d bytes over %0d key settings", texts, bytes_sent,
             settings);
    $display("%0d results checked, %0d failures", checked, fails);
    if (fails == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

FILE: json_subobject_locator.f
rtl/core/jsl_pkg.sv
rtl/core/jsl_in_reg.sv
rtl/core/jsl_scan.sv
rtl/core/jsl_out_reg.sv
rtl/core/json_subobject_locator.sv
tb/sv/span_check.sv
tb/sv/tb_top.sv
